// ----- rtl/sts_pkg.sv -----
`default_nettype none

package sts_pkg;

    localparam int TEX_ADDR_BITS   = 16;
    localparam int X_BITS          = 12;
    localparam int LIGHT_ADDR_BITS = 9;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 32;

    typedef enum logic [1:0] {
        REQ_TEXEL = 2'd0,
        REQ_LIGHT = 2'd1,
        REQ_SPAN  = 2'd2,
        REQ_SHADE = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_U_STEP     = 2'd0,
        CFG_V_STEP     = 2'd1,
        CFG_WIDTH_LOG  = 2'd2,
        CFG_HEIGHT_LOG = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                     en;
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic                     active;
        logic                     last;
        logic [X_BITS-1:0]        x;
        logic [TEX_ADDR_BITS-1:0] tex_addr;
    } span_info_t;

    function automatic logic [15:0] size_mask(input logic [3:0] lg);
        logic [16:0] one_hot;
        one_hot = 17'(1) << lg;
        return 16'(one_hot - 17'(1));
    endfunction

    function automatic logic [TEX_ADDR_BITS-1:0] tex_addr_of(
        input logic [31:0] u,
        input logic [31:0] v,
        input logic [3:0]  width_log,
        input logic [3:0]  height_log
    );
        logic [15:0] row;
        logic [15:0] col;
        logic [31:0] sum;
        row = v[31:16] & size_mask(height_log);
        col = u[31:16] & size_mask(width_log);
        sum = (32'(row) << width_log) + 32'(col);
        return sum[TEX_ADDR_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sts_tex_mem.sv -----
`default_nettype none

module sts_tex_mem (
    input  wire logic                              clk,
    input  wire logic                              wr_en,
    input  wire logic [sts_pkg::TEX_ADDR_BITS-1:0] wr_addr,
    input  wire logic [7:0]                        wr_data,
    input  wire logic                              rd_en,
    input  wire logic [sts_pkg::TEX_ADDR_BITS-1:0] rd_addr,
    output logic      [7:0]                        rd_data
);
    import sts_pkg::*;

    logic [7:0] mem [2**TEX_ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sts_light_mem.sv -----
`default_nettype none

module sts_light_mem (
    input  wire logic                                clk,
    input  wire logic                                wr_en,
    input  wire logic [sts_pkg::LIGHT_ADDR_BITS-1:0] wr_addr,
    input  wire logic [15:0]                         wr_data,
    input  wire logic                                rd_en,
    input  wire logic [15:0]                         pixel,
    output logic      [15:0]                         sum
);
    import sts_pkg::*;

    logic [15:0] mem [2**LIGHT_ADDR_BITS];
    logic [15:0] lo_q;
    logic [15:0] hi_q;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            lo_q <= mem[{1'b0, pixel[7:0]}];
            hi_q <= mem[{1'b1, pixel[15:8]}];
        end
    end

    assign sum = lo_q + hi_q;

endmodule

`default_nettype wire

// ----- rtl/sts_span_ctrl.sv -----
`default_nettype none

module sts_span_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire sts_pkg::cfg_wr_t        cfg,
    input  wire logic                    start,
    input  wire logic                    step,
    input  wire logic [11:0]             x_start,
    input  wire logic signed [31:0]      u_start,
    input  wire logic signed [31:0]      v_start,
    input  wire logic [11:0]             pixel_count,
    output sts_pkg::span_info_t          span
);
    import sts_pkg::*;

    logic [31:0]       u_step_reg;
    logic [31:0]       v_step_reg;
    logic [3:0]        width_log_reg;
    logic [3:0]        height_log_reg;
    logic [31:0]       u_pos_reg;
    logic [31:0]       v_pos_reg;
    logic [X_BITS-1:0] x_pos_reg;
    logic [11:0]       pixels_left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_step_reg     <= '0;
            v_step_reg     <= '0;
            width_log_reg  <= 4'd6;
            height_log_reg <= 4'd6;
        end
        else if (cfg.en)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_U_STEP:     u_step_reg     <= cfg.data;
                CFG_V_STEP:     v_step_reg     <= cfg.data;
                CFG_WIDTH_LOG:  width_log_reg  <= cfg.data[3:0];
                CFG_HEIGHT_LOG: height_log_reg <= cfg.data[3:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_pos_reg       <= '0;
            v_pos_reg       <= '0;
            x_pos_reg       <= '0;
            pixels_left_reg <= '0;
        end
        else if (start)
        begin
            u_pos_reg       <= u_start;
            v_pos_reg       <= v_start;
            x_pos_reg       <= X_BITS'(x_start);
            pixels_left_reg <= pixel_count;
        end
        else if (step)
        begin
            u_pos_reg       <= u_pos_reg + u_step_reg;
            v_pos_reg       <= v_pos_reg + v_step_reg;
            x_pos_reg       <= x_pos_reg + X_BITS'(1);
            pixels_left_reg <= pixels_left_reg - 12'd1;
        end
    end

    assign span.active   = (pixels_left_reg != 12'd0);
    assign span.last     = (pixels_left_reg == 12'd1);
    assign span.x        = x_pos_reg;
    assign span.tex_addr = tex_addr_of(u_pos_reg, v_pos_reg, width_log_reg, height_log_reg);

`ifndef SYNTH
    a_last_ends_span: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !start && span.last) |=> !span.active)
        else $error("span still active after last pixel");
    a_step_needs_span: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !start && !span.last) |=> span.active)
        else $error("span ended early");
    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (start && pixel_count != 12'd0) |=> span.active)
        else $error("span start did not arm the span");
`endif

endmodule

`default_nettype wire

// ----- rtl/shadow_texture_span_shader.sv -----
`default_nettype none

// channel | direction | handshake          | payload
// in      | to block  | in_valid/in_stall   | req_type addr data x_start u_start v_start pixel_count
// out     | from block| out_valid/out_stall | pixel_x write_enable pixel_value last_pixel
// cfg     | to block  | wr_en               | wr_index wr_data
//
// One item per cycle unless in_stall; shade beats pass the read stage, then the output register.
// Texel and light reads use separate memory ports, issued at accept, with registered read data.
// Reset clears span state and steps, sets size logs to 6; memories hold garbage until loaded.
// in_stall rises only when the memory read stage and the output register are both full
// and out_stall is high.

module shadow_texture_span_shader (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     req_type,
    input  wire logic [15:0]                    addr,
    input  wire logic [15:0]                    data,
    input  wire logic [11:0]                    x_start,
    input  wire logic signed [31:0]             u_start,
    input  wire logic signed [31:0]             v_start,
    input  wire logic [11:0]                    pixel_count,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [11:0]                         pixel_x,
    output logic                                write_enable,
    output logic [15:0]                         pixel_value,
    output logic                                last_pixel,
    input  wire logic                           wr_en,
    input  wire logic [sts_pkg::CFG_IDX_BITS-1:0]  wr_index,
    input  wire logic [sts_pkg::CFG_DATA_BITS-1:0] wr_data
);
    import sts_pkg::*;

    cfg_wr_t     cfg;
    span_info_t  span;
    req_t        req;
    logic        accept;
    logic        hit;
    logic        s1_move;
    logic        s1_valid_reg;
    logic [X_BITS-1:0] s1_x_reg;
    logic        s1_last_reg;
    logic [15:0] s1_dest_reg;
    logic [7:0]  texel;
    logic [15:0] lit;
    logic        out_valid_reg;
    logic [11:0] pixel_x_reg;
    logic        write_enable_reg;
    logic [15:0] pixel_value_reg;
    logic        last_pixel_reg;

    assign cfg.en    = wr_en;
    assign cfg.index = wr_index;
    assign cfg.data  = wr_data;

    assign req      = req_t'(req_type);
    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign accept   = in_valid && !in_stall;
    assign hit      = accept && (req == REQ_SHADE) && span.active;

    sts_span_ctrl u_span (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .start       (accept && (req == REQ_SPAN)),
        .step        (hit),
        .x_start     (x_start),
        .u_start     (u_start),
        .v_start     (v_start),
        .pixel_count (pixel_count),
        .span        (span)
    );

    sts_tex_mem u_tex (
        .clk     (clk),
        .wr_en   (accept && (req == REQ_TEXEL)),
        .wr_addr (addr[TEX_ADDR_BITS-1:0]),
        .wr_data (data[7:0]),
        .rd_en   (hit),
        .rd_addr (span.tex_addr),
        .rd_data (texel)
    );

    sts_light_mem u_light (
        .clk     (clk),
        .wr_en   (accept && (req == REQ_LIGHT)),
        .wr_addr (addr[LIGHT_ADDR_BITS-1:0]),
        .wr_data (data),
        .rd_en   (hit),
        .pixel   (data),
        .sum     (lit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (hit)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            s1_x_reg    <= span.x;
            s1_last_reg <= span.last;
            s1_dest_reg <= data;
        end
        if (s1_move)
        begin
            pixel_x_reg      <= 12'(s1_x_reg);
            write_enable_reg <= (texel != 8'd0);
            pixel_value_reg  <= (texel != 8'd0) ? lit : s1_dest_reg;
            last_pixel_reg   <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign write_enable = write_enable_reg;
    assign pixel_value  = pixel_value_reg;
    assign last_pixel   = last_pixel_reg;

`ifndef SYNTH
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while pipeline has room");
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_dest_reg)
            && $stable(texel) && $stable(lit)))
        else $error("read stage lost its beat while held");
    a_no_issue_while_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |-> !hit)
        else $error("memory read issued into a held stage");
`endif

endmodule

`default_nettype wire
